// ===== rtl/core/hhls_pkg.sv =====
package hhls_pkg;

  // buffer sizes, including the one slot kept spare by the length limit
  localparam int KEY_CAP = 16;
  localparam int VAL_CAP = 48;

  localparam int KEY_AW = $clog2(KEY_CAP);
  localparam int VAL_AW = $clog2(VAL_CAP);
  localparam int IDX_W  = (KEY_AW > VAL_AW) ? KEY_AW : VAL_AW;

  // fill at which a buffer counts as full: no further byte is stored once it is reached
  localparam logic [KEY_AW-1:0] KEY_LAST = KEY_AW'(KEY_CAP - 1);
  localparam logic [VAL_AW-1:0] VAL_LAST = VAL_AW'(VAL_CAP - 1);

  // characters of interest
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [7:0] MAX_HDR_RST = 8'd32;

  typedef enum logic [1:0] {
    PART_KEY  = 2'd0,
    PART_VAL  = 2'd1,
    PART_STAT = 2'd2,
    PART_SUM  = 2'd3
  } part_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_COLON = 3'd1,
    ST_KEY_LONG = 3'd2,
    ST_VAL_LONG = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_KEY,
    S_VAL,
    S_STAT,
    S_SUM
  } state_t;

endpackage

// ===== rtl/core/hhls_ram.sv =====
module hhls_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/http_header_line_splitter.sv =====
// channel | direction | beat contents
// in_     | in        | in_byte, in_block_end
// out_    | out       | out_part, out_byte, out_line_status, out_header_count, out_run_last
// cfg_    | in        | cfg_wr_data (max_headers), written when cfg_wr_en is high
//
// an input byte is taken only while the block is idle
// an accepted header is replayed from the key and value RAMs, one byte a cycle
// through their single read ports while the output is not stalled
// a rejected line end emits only its status beat; a block end adds a summary beat
// rst_n is synchronous; the RAMs are not cleared, no pass runs after reset
// a stalled output beat holds in the output register and stops the replay
module http_header_line_splitter (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_block_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_part,
  output logic [7:0] out_byte,
  output logic [2:0] out_line_status,
  output logic [7:0] out_header_count,
  output logic       out_run_last,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);
  import hhls_pkg::*;

  state_t state_r, state_nxt;

  logic [7:0] max_hdr_r;
  logic [7:0] count_r, count_nxt;

  // per-line state
  logic [KEY_AW-1:0] kfill_r, kfill_u, kfill_nxt;
  logic [KEY_AW-1:0] ktrim_r, ktrim_u, ktrim_nxt;
  logic [VAL_AW-1:0] vfill_r, vfill_u, vfill_nxt;
  logic [VAL_AW-1:0] vtrim_r, vtrim_u, vtrim_nxt;
  logic in_val_r, in_val_u, in_val_nxt;
  logic lead_r, lead_u, lead_nxt;
  logic kovf_r, kovf_u, kovf_nxt;
  logic vovf_r, vovf_u, vovf_nxt;
  logic nonempty_r, nonempty_u, nonempty_nxt;
  logic skip_r, skip_nxt;

  // replay context
  logic [KEY_AW-1:0] klen_r;
  logic [VAL_AW-1:0] vlen_r;
  status_t           stat_r, status_u;
  logic              last_pend_r;
  logic [IDX_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic              data_v_r, data_v_nxt;

  // output register
  logic       out_valid_r, out_valid_nxt;
  logic       out_load;
  part_t      out_part_r, out_part_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  status_t    out_stat_r, out_stat_nxt;
  logic [7:0] out_cnt_r, out_cnt_nxt;
  logic       out_last_r, out_last_nxt;

  logic accept, is_cr, is_colon, is_space;
  logic end_req, emit_line, clear_line, count_full;
  logic key_we, val_we, key_re, val_re;
  logic [7:0] key_rdata, val_rdata;
  logic out_free, fetch_more, move, fetch, drain_done;
  logic [IDX_W-1:0] len_sel;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign is_cr    = (in_byte == CH_CR);
  assign is_colon = (in_byte == CH_COLON);
  assign is_space = (in_byte == CH_SPACE);

  // line buffers
  hhls_ram #(.WIDTH(8), .DEPTH(KEY_CAP)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (kfill_r),
    .wdata (in_byte),
    .re    (key_re),
    .raddr (rd_idx_r[KEY_AW-1:0]),
    .rdata (key_rdata)
  );

  hhls_ram #(.WIDTH(8), .DEPTH(VAL_CAP)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (vfill_r),
    .wdata (in_byte),
    .re    (val_re),
    .raddr (rd_idx_r[VAL_AW-1:0]),
    .rdata (val_rdata)
  );

  // byte intake: split, trim and overflow tracking
  always_comb begin
    kfill_u    = kfill_r;
    ktrim_u    = ktrim_r;
    vfill_u    = vfill_r;
    vtrim_u    = vtrim_r;
    in_val_u   = in_val_r;
    lead_u     = lead_r;
    kovf_u     = kovf_r;
    vovf_u     = vovf_r;
    nonempty_u = nonempty_r;
    skip_nxt   = skip_r;
    key_we     = 1'b0;
    val_we     = 1'b0;
    end_req    = 1'b0;
    if (accept) begin
      if (skip_r) begin
        skip_nxt = 1'b0;
      end else if (is_cr) begin
        end_req  = 1'b1;
        skip_nxt = !in_block_end;
      end else begin
        nonempty_u = 1'b1;
        end_req    = in_block_end;
        if (!in_val_r && is_colon) begin
          in_val_u = 1'b1;
          lead_u   = 1'b1;
        end else if (!in_val_r) begin
          if (!kovf_r) begin
            if (is_space) begin
              if (!lead_r && (kfill_r != KEY_LAST)) begin
                key_we  = 1'b1;
                kfill_u = kfill_r + 1'b1;
              end
            end else begin
              lead_u = 1'b0;
              if (kfill_r == KEY_LAST) begin
                kovf_u = 1'b1;
              end else begin
                key_we  = 1'b1;
                kfill_u = kfill_r + 1'b1;
                ktrim_u = kfill_r + 1'b1;
              end
            end
          end
        end else begin
          if (!vovf_r) begin
            if (is_space) begin
              if (!lead_r && (vfill_r != VAL_LAST)) begin
                val_we  = 1'b1;
                vfill_u = vfill_r + 1'b1;
              end
            end else begin
              lead_u = 1'b0;
              if (vfill_r == VAL_LAST) begin
                vovf_u = 1'b1;
              end else begin
                val_we  = 1'b1;
                vfill_u = vfill_r + 1'b1;
                vtrim_u = vfill_r + 1'b1;
              end
            end
          end
        end
      end
    end
  end

  // line verdict, empty line taking precedence
  always_comb begin
    if (!nonempty_u) begin
      status_u = ST_EMPTY;
    end else if (!in_val_u) begin
      status_u = ST_NO_COLON;
    end else if (kovf_u) begin
      status_u = ST_KEY_LONG;
    end else if (vovf_u) begin
      status_u = ST_VAL_LONG;
    end else begin
      status_u = ST_OK;
    end
  end

  assign count_full = (count_r >= max_hdr_r);
  assign emit_line  = end_req && !count_full;
  assign clear_line = accept && (end_req || in_block_end);

  // line state restarts after a line end or block end
  always_comb begin
    if (clear_line) begin
      kfill_nxt    = '0;
      ktrim_nxt    = '0;
      vfill_nxt    = '0;
      vtrim_nxt    = '0;
      in_val_nxt   = 1'b0;
      lead_nxt     = 1'b1;
      kovf_nxt     = 1'b0;
      vovf_nxt     = 1'b0;
      nonempty_nxt = 1'b0;
    end else begin
      kfill_nxt    = kfill_u;
      ktrim_nxt    = ktrim_u;
      vfill_nxt    = vfill_u;
      vtrim_nxt    = vtrim_u;
      in_val_nxt   = in_val_u;
      lead_nxt     = lead_u;
      kovf_nxt     = kovf_u;
      vovf_nxt     = vovf_u;
      nonempty_nxt = nonempty_u;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (emit_line) begin
            state_nxt = (status_u == ST_OK) ? S_KEY : S_STAT;
          end else if (in_block_end) begin
            state_nxt = S_SUM;
          end
        end
      end
      S_KEY: begin
        if (drain_done) begin
          state_nxt = S_VAL;
        end
      end
      S_VAL: begin
        if (drain_done) begin
          state_nxt = S_STAT;
        end
      end
      S_STAT: begin
        if (out_free) begin
          state_nxt = last_pend_r ? S_SUM : S_IDLE;
        end
      end
      S_SUM: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // replay reads and output beats
  assign out_free = !out_valid_r || out_ready;
  assign move     = data_v_r && out_free;

  always_comb begin
    len_sel       = '0;
    fetch_more    = 1'b0;
    fetch         = 1'b0;
    drain_done    = 1'b0;
    key_re        = 1'b0;
    val_re        = 1'b0;
    out_load      = 1'b0;
    out_part_nxt  = out_part_r;
    out_byte_nxt  = out_byte_r;
    out_stat_nxt  = out_stat_r;
    out_cnt_nxt   = out_cnt_r;
    out_last_nxt  = out_last_r;
    count_nxt     = count_r;
    unique case (state_r)
      S_KEY, S_VAL: begin
        len_sel    = (state_r == S_KEY) ? IDX_W'(klen_r) : IDX_W'(vlen_r);
        fetch_more = (rd_idx_r != len_sel);
        fetch      = fetch_more && (!data_v_r || move);
        drain_done = !fetch_more && (!data_v_r || move);
        key_re     = fetch && (state_r == S_KEY);
        val_re     = fetch && (state_r == S_VAL);
        if (move) begin
          out_load     = 1'b1;
          out_part_nxt = (state_r == S_KEY) ? PART_KEY : PART_VAL;
          out_byte_nxt = (state_r == S_KEY) ? key_rdata : val_rdata;
          out_stat_nxt = ST_OK;
          out_cnt_nxt  = count_r;
          out_last_nxt = 1'b0;
        end
      end
      S_STAT: begin
        if (out_free) begin
          if (stat_r == ST_OK) begin
            count_nxt = count_r + 1'b1;
          end
          out_load     = 1'b1;
          out_part_nxt = PART_STAT;
          out_byte_nxt = 8'd0;
          out_stat_nxt = stat_r;
          out_cnt_nxt  = (stat_r == ST_OK) ? count_r + 1'b1 : count_r;
          out_last_nxt = !last_pend_r;
        end
      end
      S_SUM: begin
        if (out_free) begin
          count_nxt    = 8'd0;
          out_load     = 1'b1;
          out_part_nxt = PART_SUM;
          out_byte_nxt = 8'd0;
          out_stat_nxt = ST_OK;
          out_cnt_nxt  = count_r;
          out_last_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    if (drain_done) begin
      rd_idx_nxt = '0;
    end else if (fetch) begin
      rd_idx_nxt = rd_idx_r + 1'b1;
    end else begin
      rd_idx_nxt = rd_idx_r;
    end
  end

  assign data_v_nxt    = fetch ? 1'b1 : (move ? 1'b0 : data_v_r);
  assign out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      max_hdr_r   <= MAX_HDR_RST;
      count_r     <= 8'd0;
      kfill_r     <= '0;
      ktrim_r     <= '0;
      vfill_r     <= '0;
      vtrim_r     <= '0;
      in_val_r    <= 1'b0;
      lead_r      <= 1'b1;
      kovf_r      <= 1'b0;
      vovf_r      <= 1'b0;
      nonempty_r  <= 1'b0;
      skip_r      <= 1'b0;
      last_pend_r <= 1'b0;
      rd_idx_r    <= '0;
      data_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_wr_en) begin
        max_hdr_r <= cfg_wr_data;
      end
      count_r     <= count_nxt;
      kfill_r     <= kfill_nxt;
      ktrim_r     <= ktrim_nxt;
      vfill_r     <= vfill_nxt;
      vtrim_r     <= vtrim_nxt;
      in_val_r    <= in_val_nxt;
      lead_r      <= lead_nxt;
      kovf_r      <= kovf_nxt;
      vovf_r      <= vovf_nxt;
      nonempty_r  <= nonempty_nxt;
      skip_r      <= skip_nxt;
      if (accept) begin
        last_pend_r <= in_block_end;
      end
      rd_idx_r    <= rd_idx_nxt;
      data_v_r    <= data_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      klen_r <= ktrim_u;
      vlen_r <= vtrim_u;
      stat_r <= status_u;
    end
    out_part_r <= out_part_nxt;
    out_byte_r <= out_byte_nxt;
    out_stat_r <= out_stat_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_part         = out_part_r;
  assign out_byte         = out_byte_r;
  assign out_line_status  = out_stat_r;
  assign out_header_count = out_cnt_r;
  assign out_run_last     = out_last_r;

endmodule

// ===== rtl/core/hhls_checker.sv =====
module hhls_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_part,
  input logic [7:0] out_byte,
  input logic [2:0] out_line_status,
  input logic [7:0] out_header_count,
  input logic       out_run_last
);
  import hhls_pkg::*;

  // a stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_part) && $stable(out_byte)
      && $stable(out_line_status) && $stable(out_header_count) && $stable(out_run_last))
    else $error("result beat changed while stalled");

  // key and value bytes are never the last beat of a run and carry status ok
  a_byte_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_part == PART_KEY || out_part == PART_VAL) |->
      !out_run_last && out_line_status == ST_OK)
    else $error("key or value beat flagged as last");

  // the summary closes the work of its input byte
  a_sum_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_part == PART_SUM |-> out_run_last && out_line_status == ST_OK)
    else $error("summary beat without run_last");

  // no new byte is taken while a header is being replayed
  a_no_intake_in_replay: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_part == PART_KEY || out_part == PART_VAL) |-> !in_ready)
    else $error("input taken during header replay");

endmodule

bind http_header_line_splitter hhls_checker u_hhls_checker (.*);

// ===== tb/tb.sv =====
module tb;
  import hhls_pkg::*;

  localparam int TIMEOUT_CYCLES = 600000;
  localparam int PHASE_BYTES    = 32;
  localparam int SETTLE_CYCLES  = 80;

  // one result beat as it leaves the splitter
  typedef struct {
    part_t      part;
    logic [7:0] data;
    status_t    stat;
    logic [7:0] cnt;
    logic       tail;
  } hdr_beat_t;

  // one input byte, optionally with its single result typed in by hand
  typedef struct {
    logic [7:0] b;
    logic       be;
    bit         typed;
    hdr_beat_t  want;
  } stim_row_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte;
  logic       in_block_end;
  logic       out_valid;
  logic       out_ready;
  logic [1:0] out_part;
  logic [7:0] out_byte;
  logic [2:0] out_line_status;
  logic [7:0] out_header_count;
  logic       out_run_last;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;

  http_header_line_splitter dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte          (in_byte),
    .in_block_end     (in_block_end),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_part         (out_part),
    .out_byte         (out_byte),
    .out_line_status  (out_line_status),
    .out_header_count (out_header_count),
    .out_run_last     (out_run_last),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  // splitter state as the testbench sees it
  logic [7:0]  max_hdr;
  logic [7:0]  key_mem [KEY_CAP];
  logic [7:0]  val_mem [VAL_CAP];
  int unsigned k_fill, k_trim, v_fill, v_trim;
  bit          in_val, lead_sp, k_ovf, v_ovf, nonempty, skip_nxt;
  logic [7:0]  n_accepted;

  hdr_beat_t   header_beats_q [$];
  stim_row_t   script_q [$];
  stim_row_t   dir_tab [$];
  int          mismatches;
  int          cycles;
  bit          no_idle;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic stim_row_t plain(input logic [7:0] b, input logic be);
    stim_row_t r;
    r.b     = b;
    r.be    = be;
    r.typed = 1'b0;
    r.want  = '{PART_KEY, 8'h00, ST_OK, 8'h00, 1'b0};
    return r;
  endfunction

  function automatic stim_row_t typed_row(input logic [7:0] b, input logic be,
                                          input part_t p, input status_t s,
                                          input logic [7:0] c);
    stim_row_t r;
    r       = plain(b, be);
    r.typed = 1'b1;
    r.want  = '{p, 8'h00, s, c, 1'b1};
    return r;
  endfunction

  // line bookkeeping
  function automatic void wipe_line();
    k_fill   = 0;
    k_trim   = 0;
    v_fill   = 0;
    v_trim   = 0;
    in_val   = 1'b0;
    lead_sp  = 1'b1;
    k_ovf    = 1'b0;
    v_ovf    = 1'b0;
    nonempty = 1'b0;
  endfunction

  function automatic void emit(input part_t p, input logic [7:0] d,
                               input status_t s, input logic [7:0] c);
    header_beats_q.push_back('{p, d, s, c, 1'b0});
  endfunction

  // store a key or value byte, trimming spaces and tracking overflow
  function automatic void stash(input bit to_val, input logic [7:0] c);
    int unsigned cap, fill, trim;
    bit ovf;
    cap  = to_val ? VAL_CAP : KEY_CAP;
    fill = to_val ? v_fill : k_fill;
    trim = to_val ? v_trim : k_trim;
    ovf  = to_val ? v_ovf : k_ovf;
    if (!ovf) begin
      if (c == CH_SPACE) begin
        if (!lead_sp && fill < cap - 1) begin
          if (to_val) val_mem[fill] = c;
          else key_mem[fill] = c;
          fill++;
        end
      end else begin
        lead_sp = 1'b0;
        if (fill >= cap - 1) begin
          ovf = 1'b1;
        end else begin
          if (to_val) val_mem[fill] = c;
          else key_mem[fill] = c;
          fill++;
          trim = fill;
        end
      end
    end
    if (to_val) begin
      v_fill = fill;
      v_trim = trim;
      v_ovf  = ovf;
    end else begin
      k_fill = fill;
      k_trim = trim;
      k_ovf  = ovf;
    end
  endfunction

  // a line has ended: replay it or report why not, unless the header limit is reached
  function automatic void close_line();
    status_t st;
    if (n_accepted < max_hdr) begin
      if (!nonempty) st = ST_EMPTY;
      else if (!in_val) st = ST_NO_COLON;
      else if (k_ovf) st = ST_KEY_LONG;
      else if (v_ovf) st = ST_VAL_LONG;
      else st = ST_OK;
      if (st == ST_OK) begin
        for (int i = 0; i < k_trim; i++) emit(PART_KEY, key_mem[i], ST_OK, n_accepted);
        for (int i = 0; i < v_trim; i++) emit(PART_VAL, val_mem[i], ST_OK, n_accepted);
        n_accepted++;
      end
      emit(PART_STAT, 8'h00, st, n_accepted);
    end
    wipe_line();
  endfunction

  // predict the beats caused by one accepted input byte
  function automatic int parse_byte(input logic [7:0] c, input logic be);
    int first;
    first = header_beats_q.size();
    if (skip_nxt) begin
      skip_nxt = 1'b0;
    end else if (c == CH_CR) begin
      close_line();
      skip_nxt = !be;
    end else begin
      nonempty = 1'b1;
      if (!in_val && c == CH_COLON) begin
        in_val  = 1'b1;
        lead_sp = 1'b1;
      end else begin
        stash(in_val, c);
      end
      if (be) close_line();
    end
    if (be) begin
      emit(PART_SUM, 8'h00, ST_OK, n_accepted);
      n_accepted = 8'h00;
      skip_nxt   = 1'b0;
      wipe_line();
    end
    if (header_beats_q.size() > first)
      header_beats_q[header_beats_q.size() - 1].tail = 1'b1;
    return header_beats_q.size() - first;
  endfunction

  // random text byte: anything but space, colon and carriage return
  function automatic logic [7:0] text_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (c == CH_SPACE || c == CH_COLON || c == CH_CR) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic void add_char(input logic [7:0] c, input logic be);
    script_q.push_back(plain(c, be));
  endfunction

  function automatic void add_spaces(input int n);
    for (int i = 0; i < n; i++) add_char(CH_SPACE, 1'b0);
  endfunction

  // one line of the header block, mostly well formed
  function automatic void add_random_line();
    int kind, klen, vlen;
    bit cr_end;
    kind   = $urandom_range(0, 99);
    cr_end = 1'b1;
    if (kind < 60) begin
      klen = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 17) : $urandom_range(0, 6);
      vlen = ($urandom_range(0, 9) == 0) ? $urandom_range(46, 49) : $urandom_range(0, 8);
      add_spaces($urandom_range(0, 2));
      for (int i = 0; i < klen; i++)
        add_char((i > 0 && i < klen - 1 && $urandom_range(0, 5) == 0) ? CH_SPACE : text_char(),
                 1'b0);
      add_spaces($urandom_range(0, 2));
      add_char(CH_COLON, 1'b0);
      add_spaces($urandom_range(0, 2));
      for (int i = 0; i < vlen; i++) begin
        case ($urandom_range(0, 7))
          0: add_char(CH_COLON, 1'b0);
          1: add_char((i > 0 && i < vlen - 1) ? CH_SPACE : text_char(), 1'b0);
          default: add_char(text_char(), 1'b0);
        endcase
      end
      add_spaces($urandom_range(0, 2));
      if ($urandom_range(0, 7) == 0) begin
        script_q[script_q.size() - 1].be = 1'b1;
        cr_end = 1'b0;
      end
    end else if (kind < 72) begin
      repeat ($urandom_range(1, 6)) add_char(8'($urandom_range(0, 255)), 1'b0);
    end else if (kind < 88) begin
      // no colon: text or spaces alone
      if ($urandom_range(0, 1)) repeat ($urandom_range(1, 5)) add_char(text_char(), 1'b0);
      else add_spaces($urandom_range(1, 3));
    end else if (kind < 94) begin
      // block ends on a bare byte
      add_char(8'($urandom_range(0, 255)), 1'b1);
      cr_end = 1'b0;
    end
    if (cr_end) begin
      add_char(CH_CR, ($urandom_range(0, 15) == 0));
      if (!script_q[script_q.size() - 1].be)
        add_char(8'($urandom_range(0, 255)), ($urandom_range(0, 11) == 0));
    end
  endfunction

  // drive one input beat and predict its results once it is taken
  task automatic push_beat(input stim_row_t row);
    int gap, n;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_byte      <= row.b;
    in_block_end <= row.be;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n = parse_byte(row.b, row.be);
    if (row.typed) begin
      repeat (n) void'(header_beats_q.pop_back());
      header_beats_q.push_back(row.want);
    end
    @(negedge clk);
  endtask

  // let the splitter go idle before touching the register
  task automatic settle();
    in_valid <= 1'b0;
    while (header_beats_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_max_headers(input logic [7:0] v);
    cfg_wr_data <= v;
    cfg_wr_en   <= 1'b1;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    max_hdr      = v;
  endtask

  // stimulus
  initial begin
    logic [7:0] limits [5];
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_byte      = 8'h00;
    in_block_end = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = 8'h00;
    no_idle      = 1'b0;
    mismatches   = 0;
    max_hdr      = MAX_HDR_RST;
    n_accepted   = 8'h00;
    skip_nxt     = 1'b0;
    wipe_line();
    for (int i = 0; i < KEY_CAP; i++) key_mem[i] = 8'h00;
    for (int i = 0; i < VAL_CAP; i++) val_mem[i] = 8'h00;

    dir_tab = '{
      typed_row(CH_CR, 1'b0, PART_STAT, ST_EMPTY, 8'd0),      // empty line
      plain(8'hFF, 1'b0),                                     // skipped after cr
      plain(8'h00, 1'b0),
      plain(CH_COLON, 1'b0),
      plain(CH_SPACE, 1'b0),
      plain(CH_COLON, 1'b0),                                  // later colon is value
      plain(8'hFF, 1'b0),
      plain(CH_SPACE, 1'b0),                                  // trailing space trimmed
      plain(CH_CR, 1'b0),
      plain(CH_CR, 1'b0),                                     // skipped, even a cr
      plain(8'h6E, 1'b0),
      typed_row(CH_CR, 1'b0, PART_STAT, ST_NO_COLON, 8'd1),
      plain(8'h00, 1'b0),
      plain(CH_SPACE, 1'b0),                                  // spaces only: not empty
      typed_row(CH_CR, 1'b0, PART_STAT, ST_NO_COLON, 8'd1),
      plain(CH_SPACE, 1'b0),
      plain(CH_COLON, 1'b0),                                  // empty key and value
      typed_row(CH_CR, 1'b0, PART_STAT, ST_OK, 8'd2),
      typed_row(CH_CR, 1'b1, PART_SUM, ST_OK, 8'd2),         // skipped byte ends block
      plain(CH_CR, 1'b1),                                     // cr carrying block end
      plain(8'h7A, 1'b1),
      plain(CH_COLON, 1'b0),
      plain(8'h76, 1'b1)
    };

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part at the reset limit
    foreach (dir_tab[i]) push_beat(dir_tab[i]);

    // random part over several limits, extremes included
    limits = '{8'd0, 8'd255, 8'd1, 8'd2, 8'($urandom_range(3, 8))};
    for (int ph = 0; ph < 5; ph++) begin
      settle();
      set_max_headers(limits[ph]);
      no_idle = (ph == 2);
      script_q.delete();
      while (script_q.size() < PHASE_BYTES) add_random_line();
      add_char(8'($urandom_range(0, 255)), 1'b1);
      foreach (script_q[i]) push_beat(script_q[i]);
    end
    no_idle = 1'b0;

    in_valid <= 1'b0;
    while (header_beats_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // result side back-pressure
  initial begin
    int gap;
    out_ready = 1'b0;
    while (!rst_n) @(negedge clk);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // compare each result beat with the oldest prediction; watchdog
  always @(posedge clk) begin
    hdr_beat_t exp_beat;
    cycles <= cycles + 1;
    if (cycles > TIMEOUT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end else if (rst_n && out_valid && out_ready) begin
      if (header_beats_q.size() == 0) begin
        $error("unexpected result beat: part %0d byte %0d", out_part, out_byte);
        mismatches++;
      end else begin
        exp_beat = header_beats_q.pop_front();
        check_field("out_part", 8'(exp_beat.part), 8'(out_part));
        check_field("out_byte", exp_beat.data, out_byte);
        check_field("out_line_status", 8'(exp_beat.stat), 8'(out_line_status));
        check_field("out_header_count", exp_beat.cnt, out_header_count);
        check_field("out_run_last", 8'(exp_beat.tail), 8'(out_run_last));
      end
    end
  end

  initial cycles = 0;

endmodule

// ===== filelist.f =====
rtl/core/hhls_pkg.sv
rtl/core/hhls_ram.sv
rtl/core/http_header_line_splitter.sv
rtl/core/hhls_checker.sv
tb/tb.sv
